>>> rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Balance cascade controller package
// Sequencer states, register indexes and fixed datapath widths.
// ----------------------------------------------------------------------------
package bcc_pkg;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_MIX   = 16'h0002,
    S_RECIP = 16'h0004,
    S_QUOT  = 16'h0008,
    S_INTEG = 16'h0010,
    S_SPI   = 16'h0020,
    S_SPSUM = 16'h0040,
    S_VEL   = 16'h0080,
    S_DEV   = 16'h0100,
    S_BAL   = 16'h0200,
    S_BSUM  = 16'h0400,
    S_BDIV  = 16'h0800,
    S_TSUM  = 16'h1000,
    S_TDIV  = 16'h2000,
    S_RSUM  = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  typedef logic [3:0] reg_index_t;

  localparam reg_index_t REG_MID_ANGLE    = 4'd0;
  localparam reg_index_t REG_TILT_GAIN_P  = 4'd1;
  localparam reg_index_t REG_TILT_GAIN_D  = 4'd2;
  localparam reg_index_t REG_SPEED_GAIN_P = 4'd3;
  localparam reg_index_t REG_SPEED_GAIN_I = 4'd4;
  localparam reg_index_t REG_YAW_GAIN_D   = 4'd5;
  localparam reg_index_t REG_YAW_GAIN_CMD = 4'd6;
  localparam reg_index_t REG_DRIVE_LIMIT  = 4'd7;

  localparam int CFG_DATA_W = 32;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FILT_W     = 18;
  localparam int INTEG_W    = 16;
  localparam int MIX_W      = 22;
  localparam int BAL_W      = 35;
  localparam int TURN_W     = 33;
  localparam int RAW_W      = 36;

  // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for 0 <= x < 2^22
  localparam logic signed [MUL_A_W-1:0] RECIP_TEN   = 32'sd3355444;
  localparam int                        RECIP_SHIFT = 25;

  localparam logic signed [16:0] MID_ANGLE_RST    = 17'sd0;
  localparam logic signed [31:0] TILT_GAIN_P_RST  = -32'sd26214400;
  localparam logic signed [31:0] TILT_GAIN_D_RST  = -32'sd127795;
  localparam logic signed [31:0] SPEED_GAIN_P_RST = -32'sd28836;
  localparam logic signed [31:0] SPEED_GAIN_I_RST = -32'sd144;
  localparam logic signed [31:0] YAW_GAIN_D_RST   = 32'sd39322;
  localparam logic signed [31:0] YAW_GAIN_CMD_RST = 32'sd0;
  localparam logic [14:0]        DRIVE_LIMIT_RST  = 15'd7200;

endpackage

>>> rtl/balance_cascade_controller.sv
// ----------------------------------------------------------------------------
// Balance cascade controller
// Speed PI loop feeding a pitch PD balance loop with a yaw turn term, for a
// two-wheel balancing platform. One shared 32x25 multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Tick channel (item_valid / item_stall): one word per control tick carrying
//   encoder counts, pitch, rates, speed target, turn command and clear flag.
//   Result channel (result_valid / result_stall): one word per tick with both
//   clamped motor drives and the saturation flag.
//   Config channel (cfg_valid / cfg_ready): register index and data; write
//   only while no tick is in flight. Indexes 8 and above are ignored.
// Sequencing:
//   A word is taken only in the idle state; the sequencer then steps seven
//   products through the one multiplier plus the filter, integrator,
//   truncation and clamp steps around it, and takes the next tick only once
//   the result has been loaded into the output register.
// Reset:
//   Gains and limit return to their defaults, filter and integrator clear.
// Stall:
//   The result sits in an output register; a stalled result holds the
//   sequencer in its last step until the register frees.
// ----------------------------------------------------------------------------
module balance_cascade_controller #(
  parameter int INTEGRAL_LIMIT = 20000
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic signed [15:0]       count_left,
  input  logic signed [15:0]       count_right,
  input  logic signed [16:0]       pitch_angle,
  input  logic signed [15:0]       pitch_rate,
  input  logic signed [15:0]       yaw_rate,
  input  logic signed [15:0]       speed_target,
  input  logic signed [15:0]       turn_command,
  input  logic                     clear_integral,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [15:0]       drive_left,
  output logic signed [15:0]       drive_right,
  output logic                     saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  bcc_pkg::reg_index_t      cfg_index,
  input  logic [31:0]              cfg_data
);
  import bcc_pkg::*;

  localparam logic signed [ACC_W-1:0] VEL_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] VEL_MIN = -ACC_W'(32768);
  localparam logic signed [FILT_W:0]  ILIM    = (FILT_W+1)'(INTEGRAL_LIMIT);

  state_t state;

  logic signed [16:0] mid_angle;
  logic signed [31:0] tilt_gain_p;
  logic signed [31:0] tilt_gain_d;
  logic signed [31:0] speed_gain_p;
  logic signed [31:0] speed_gain_i;
  logic signed [31:0] yaw_gain_d;
  logic signed [31:0] yaw_gain_cmd;
  logic [14:0]        drive_limit;

  logic signed [15:0] cl, cr, prate, yrate, tgt, cmd;
  logic signed [16:0] pitch;
  logic               clr;

  logic signed [FILT_W-1:0]  filt;
  logic signed [INTEG_W-1:0] integ;
  logic [MIX_W-2:0]          x_abs;
  logic                      x_neg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [15:0]        vel;
  logic signed [MUL_B_W-1:0] dev;
  logic signed [BAL_W-1:0]   bal;
  logic signed [TURN_W-1:0]  turn;
  logic signed [RAW_W-1:0]   raw_l, raw_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [FILT_W-1:0]  err;
  logic signed [MIX_W-1:0]   mix;
  logic signed [MIX_W-1:0]   mix_abs;
  logic signed [FILT_W-1:0]  filt_next;
  logic signed [FILT_W:0]    isum;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   t16, t24;
  logic signed [15:0]        vel_next;
  logic signed [MUL_B_W-1:0] dev_next;
  logic signed [RAW_W-1:0]   lim_p, lim_n;
  logic signed [15:0]        drive_left_next, drive_right_next;
  logic                      sat_next;
  logic                      load_ok;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign load_ok    = !result_valid || !result_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_angle    <= MID_ANGLE_RST;
      tilt_gain_p  <= TILT_GAIN_P_RST;
      tilt_gain_d  <= TILT_GAIN_D_RST;
      speed_gain_p <= SPEED_GAIN_P_RST;
      speed_gain_i <= SPEED_GAIN_I_RST;
      yaw_gain_d   <= YAW_GAIN_D_RST;
      yaw_gain_cmd <= YAW_GAIN_CMD_RST;
      drive_limit  <= DRIVE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MID_ANGLE:    mid_angle    <= cfg_data[16:0];
        REG_TILT_GAIN_P:  tilt_gain_p  <= cfg_data;
        REG_TILT_GAIN_D:  tilt_gain_d  <= cfg_data;
        REG_SPEED_GAIN_P: speed_gain_p <= cfg_data;
        REG_SPEED_GAIN_I: speed_gain_i <= cfg_data;
        REG_YAW_GAIN_D:   yaw_gain_d   <= cfg_data;
        REG_YAW_GAIN_CMD: yaw_gain_cmd <= cfg_data;
        REG_DRIVE_LIMIT:  drive_limit  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_RECIP: begin
        mul_a = RECIP_TEN;
        mul_b = {{(MUL_B_W-MIX_W+1){1'b0}}, x_abs};
      end
      S_INTEG: begin
        mul_a = speed_gain_p;
        mul_b = {{(MUL_B_W-FILT_W){filt[FILT_W-1]}}, filt};
      end
      S_SPI: begin
        mul_a = speed_gain_i;
        mul_b = {{(MUL_B_W-INTEG_W){integ[INTEG_W-1]}}, integ};
      end
      S_VEL: begin
        mul_a = tilt_gain_d;
        mul_b = {{(MUL_B_W-16){prate[15]}}, prate};
      end
      S_BAL: begin
        mul_a = tilt_gain_p;
        mul_b = dev;
      end
      S_BSUM: begin
        mul_a = yaw_gain_d;
        mul_b = {{(MUL_B_W-16){yrate[15]}}, yrate};
      end
      S_BDIV: begin
        mul_a = yaw_gain_cmd;
        mul_b = {{(MUL_B_W-16){cmd[15]}}, cmd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    err = {{2{cl[15]}}, cl} + {{2{cr[15]}}, cr} - {{2{tgt[15]}}, tgt};
    mix = ({{(MIX_W-FILT_W){err[FILT_W-1]}}, err} <<< 1)
        + {{(MIX_W-FILT_W){err[FILT_W-1]}}, err}
        + ({{(MIX_W-FILT_W){filt[FILT_W-1]}}, filt} <<< 3)
        - {{(MIX_W-FILT_W){filt[FILT_W-1]}}, filt};
    mix_abs = mix[MIX_W-1] ? -mix : mix;

    filt_next = {1'b0, prod[RECIP_SHIFT +: FILT_W-1]};
    if (x_neg) begin
      filt_next = -filt_next;
    end

    isum = {filt[FILT_W-1], filt}
         + {{(FILT_W+1-INTEG_W){integ[INTEG_W-1]}}, integ};
    if (clr) begin
      integ_next = '0;
    end else if (isum > ILIM) begin
      integ_next = ILIM[INTEG_W-1:0];
    end else if (isum < -ILIM) begin
      integ_next = -ILIM[INTEG_W-1:0];
    end else begin
      integ_next = isum[INTEG_W-1:0];
    end

    prod_ext = {prod[PROD_W-1], prod};
    t16 = (acc + (acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0))) >>> 16;
    t24 = (acc + (acc[ACC_W-1] ? ACC_W'(16777215) : ACC_W'(0))) >>> 24;

    if (t16 > VEL_MAX) begin
      vel_next = 16'sh7FFF;
    end else if (t16 < VEL_MIN) begin
      vel_next = -16'sh8000;
    end else begin
      vel_next = t16[15:0];
    end

    dev_next = {{(MUL_B_W-17){pitch[16]}}, pitch}
             - {vel[15], vel, 8'h00}
             - {{(MUL_B_W-17){mid_angle[16]}}, mid_angle};

    lim_p = {{(RAW_W-15){1'b0}}, drive_limit};
    lim_n = -lim_p;
    sat_next = (raw_l > lim_p) || (raw_l < lim_n) || (raw_r > lim_p) || (raw_r < lim_n);
    if (raw_l > lim_p) begin
      drive_left_next = lim_p[15:0];
    end else if (raw_l < lim_n) begin
      drive_left_next = lim_n[15:0];
    end else begin
      drive_left_next = raw_l[15:0];
    end
    if (raw_r > lim_p) begin
      drive_right_next = lim_p[15:0];
    end else if (raw_r < lim_n) begin
      drive_right_next = lim_n[15:0];
    end else begin
      drive_right_next = raw_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      filt         <= '0;
      integ        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_MIX;
          end
        end
        S_MIX:   state <= S_RECIP;
        S_RECIP: state <= S_QUOT;
        S_QUOT: begin
          filt  <= filt_next;
          state <= S_INTEG;
        end
        S_INTEG: begin
          integ <= integ_next;
          state <= S_SPI;
        end
        S_SPI:   state <= S_SPSUM;
        S_SPSUM: state <= S_VEL;
        S_VEL:   state <= S_DEV;
        S_DEV:   state <= S_BAL;
        S_BAL:   state <= S_BSUM;
        S_BSUM:  state <= S_BDIV;
        S_BDIV:  state <= S_TSUM;
        S_TSUM:  state <= S_TDIV;
        S_TDIV:  state <= S_RSUM;
        S_RSUM:  state <= S_DONE;
        S_DONE: begin
          if (load_ok) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cl    <= count_left;
          cr    <= count_right;
          pitch <= pitch_angle;
          prate <= pitch_rate;
          yrate <= yaw_rate;
          tgt   <= speed_target;
          cmd   <= turn_command;
          clr   <= clear_integral;
        end
      end
      S_MIX: begin
        x_abs <= mix_abs[MIX_W-2:0];
        x_neg <= mix[MIX_W-1];
      end
      S_SPI:   acc <= prod_ext;
      S_SPSUM: acc <= acc + prod_ext;
      S_VEL:   vel <= vel_next;
      S_DEV: begin
        dev <= dev_next;
        acc <= prod_ext <<< 8;
      end
      S_BSUM:  acc <= acc + prod_ext;
      S_BDIV: begin
        bal <= t24[BAL_W-1:0];
        acc <= prod_ext;
      end
      S_TSUM:  acc <= acc + prod_ext;
      S_TDIV:  turn <= t16[TURN_W-1:0];
      S_RSUM: begin
        raw_l <= {bal[BAL_W-1], bal} - {{(RAW_W-TURN_W){turn[TURN_W-1]}}, turn};
        raw_r <= {bal[BAL_W-1], bal} + {{(RAW_W-TURN_W){turn[TURN_W-1]}}, turn};
      end
      S_DONE: begin
        if (load_ok) begin
          drive_left  <= drive_left_next;
          drive_right <= drive_right_next;
          saturated   <= sat_next;
        end
      end
      default: ;
    endcase
  end

  // checks
  logic signed [15:0] lim16;
  assign lim16 = {1'b0, drive_limit};

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result word appeared outside the final step");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (integ <= $signed(ILIM[INTEG_W-1:0])) && (integ >= -$signed(ILIM[INTEG_W-1:0])))
    else $error("speed integral beyond its limit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && saturated) |->
      (drive_left == lim16 || drive_left == -lim16 ||
       drive_right == lim16 || drive_right == -lim16))
    else $error("saturation flagged with no drive at the limit");

  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (drive_left <= lim16 && drive_left >= -lim16 &&
       drive_right <= lim16 && drive_right >= -lim16))
    else $error("drive beyond limit");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Balance cascade controller testbench
// Ticks are driven in random bursts while the result side stalls on patterns
// of its own. Each accepted tick is run through a bit-exact behavioral copy of
// the speed PI / balance PD / turn cascade, and the drive words that come out
// are compared field by field. The run covers defaults, extreme gains, zero
// and full limits, ignored register indexes and random register settings.
// ----------------------------------------------------------------------------
module tb;
  import bcc_pkg::*;

  localparam int         INTEG_LIMIT        = 20000;
  localparam int         N_SETTINGS         = 9;
  localparam int         RANDOM_PER_SETTING = 220;
  localparam int         LONG_HOLD          = 300;
  localparam int         WATCHDOG_LIMIT     = 2000;
  localparam int         TAIL_CYCLES        = 40;
  localparam reg_index_t REG_UNUSED_LO      = 4'd8;
  localparam reg_index_t REG_UNUSED_HI      = 4'd15;

  typedef struct {
    logic signed [15:0] count_left;
    logic signed [15:0] count_right;
    logic signed [16:0] pitch_angle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] speed_target;
    logic signed [15:0] turn_command;
    logic               clear_integral;
  } tick_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               sat;
  } drive_t;

  typedef struct {
    reg_index_t  idx;
    logic [31:0] data;
  } reg_write_t;

  typedef enum int {FLOW, LIGHT, HEAVY, PERIODIC, HOLD} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic signed [15:0] count_left = '0;
  logic signed [15:0] count_right = '0;
  logic signed [16:0] pitch_angle = '0;
  logic signed [15:0] pitch_rate = '0;
  logic signed [15:0] yaw_rate = '0;
  logic signed [15:0] speed_target = '0;
  logic signed [15:0] turn_command = '0;
  logic               clear_integral = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [15:0] drive_left;
  logic signed [15:0] drive_right;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  reg_index_t         cfg_index = REG_MID_ANGLE;
  logic [31:0]        cfg_data = '0;

  // controller copy: registers and loop state
  longint set_mid     = longint'(MID_ANGLE_RST);
  longint k_tilt_p    = longint'(TILT_GAIN_P_RST);
  longint k_tilt_d    = longint'(TILT_GAIN_D_RST);
  longint k_speed_p   = longint'(SPEED_GAIN_P_RST);
  longint k_speed_i   = longint'(SPEED_GAIN_I_RST);
  longint k_yaw_d     = longint'(YAW_GAIN_D_RST);
  longint k_yaw_cmd   = longint'(YAW_GAIN_CMD_RST);
  longint drive_lim   = longint'(DRIVE_LIMIT_RST);
  longint filt_err    = 0;
  longint speed_sum   = 0;

  tick_t      tick_q[$];
  drive_t     drive_q[$];
  reg_write_t reg_q[$];

  int          ticks_sent = 0;
  int          drives_checked = 0;
  int          mismatches = 0;
  int          sat_seen = 0;
  int          clears_sent = 0;
  int          reg_writes = 0;
  int          settings_run = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  int          seg_left = 0;
  bit          taken;
  bit          stall_next;
  bit          hold_toggle = 1'b0;
  bit          hold_seen = 1'b0;
  stall_mode_t stall_mode = FLOW;
  drive_t      want;

  balance_cascade_controller #(
    .INTEGRAL_LIMIT(INTEG_LIMIT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .count_left    (count_left),
    .count_right   (count_right),
    .pitch_angle   (pitch_angle),
    .pitch_rate    (pitch_rate),
    .yaw_rate      (yaw_rate),
    .speed_target  (speed_target),
    .turn_command  (turn_command),
    .clear_integral(clear_integral),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .drive_left    (drive_left),
    .drive_right   (drive_right),
    .saturated     (saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic void write_register(reg_index_t idx, logic [31:0] data);
    case (idx)
      REG_MID_ANGLE:    set_mid = longint'($signed(data[16:0]));
      REG_TILT_GAIN_P:  k_tilt_p = longint'($signed(data));
      REG_TILT_GAIN_D:  k_tilt_d = longint'($signed(data));
      REG_SPEED_GAIN_P: k_speed_p = longint'($signed(data));
      REG_SPEED_GAIN_I: k_speed_i = longint'($signed(data));
      REG_YAW_GAIN_D:   k_yaw_d = longint'($signed(data));
      REG_YAW_GAIN_CMD: k_yaw_cmd = longint'($signed(data));
      REG_DRIVE_LIMIT:  drive_lim = longint'(data[14:0]);
      default: ;
    endcase
  endfunction

  // one control tick: filter, integrate, speed PI, balance PD, turn split
  function automatic drive_t step_controller(tick_t t);
    longint err, filt, integ, vel, setp, bal, turn, raw_l, raw_r, dl, dr;
    drive_t d;
    err = longint'(t.count_left) + longint'(t.count_right) - longint'(t.speed_target);
    filt = (3 * err + 7 * filt_err) / 10;
    filt_err = filt;
    integ = clip(speed_sum + filt, -longint'(INTEG_LIMIT), longint'(INTEG_LIMIT));
    if (t.clear_integral) integ = 0;
    speed_sum = integ;
    vel = clip((k_speed_p * filt + k_speed_i * integ) / 65536, -32768, 32767);
    setp = vel * 256 + set_mid;
    bal = (k_tilt_p * (longint'(t.pitch_angle) - setp)
           + k_tilt_d * longint'(t.pitch_rate) * 256) / 16777216;
    turn = (k_yaw_d * longint'(t.yaw_rate) + k_yaw_cmd * longint'(t.turn_command)) / 65536;
    raw_l = bal - turn;
    raw_r = bal + turn;
    d.sat = (raw_l > drive_lim) || (raw_l < -drive_lim) ||
            (raw_r > drive_lim) || (raw_r < -drive_lim);
    dl = clip(raw_l, -drive_lim, drive_lim);
    dr = clip(raw_r, -drive_lim, drive_lim);
    d.left = dl[15:0];
    d.right = dr[15:0];
    return d;
  endfunction

  function automatic longint random_bits(int w);
    return (longint'($urandom) <<< (64 - w)) >>> (64 - w);
  endfunction

  function automatic longint rand_field(int w);
    longint m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return random_bits(w);
      8: return (longint'(1) <<< (w - 1)) - 1;
      9: return -(longint'(1) <<< (w - 1));
      default: begin
        m = longint'(1) <<< $urandom_range(0, 10);
        return longint'($urandom_range(0, 2 * m)) - m;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return 32'(random_bits($urandom_range(2, 30)));
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.count_left = 16'(rand_field(16));
    t.count_right = 16'(rand_field(16));
    t.pitch_angle = 17'(rand_field(17));
    t.pitch_rate = 16'(rand_field(16));
    t.yaw_rate = 16'(rand_field(16));
    t.speed_target = 16'(rand_field(16));
    t.turn_command = 16'(rand_field(16));
    t.clear_integral = ($urandom_range(0, 9) == 0);
    return t;
  endfunction

  function automatic void add_tick(int cl, int cr, int pa, int pr, int yr, int tg, int tc,
                                   bit clr);
    tick_t t;
    t.count_left = 16'(cl);
    t.count_right = 16'(cr);
    t.pitch_angle = 17'(pa);
    t.pitch_rate = 16'(pr);
    t.yaw_rate = 16'(yr);
    t.speed_target = 16'(tg);
    t.turn_command = 16'(tc);
    t.clear_integral = clr;
    tick_q.push_back(t);
  endfunction

  function automatic void queue_write(reg_index_t idx, logic [31:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_q.push_back(w);
  endfunction

  task automatic apply_settings();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_q[0].idx;
    cfg_data <= reg_q[0].data;
    while (reg_q.size() != 0) begin
      @(posedge clk);
      if (cfg_valid && cfg_ready) begin
        write_register(reg_q[0].idx, reg_q[0].data);
        void'(reg_q.pop_front());
        reg_writes++;
        if (reg_q.size() == 0) begin
          cfg_valid <= 1'b0;
        end else begin
          cfg_index <= reg_q[0].idx;
          cfg_data <= reg_q[0].data;
        end
      end
    end
  endtask

  // tick driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      taken = item_valid && !item_stall;
      if (taken) begin
        drive_q.push_back(step_controller(tick_q[0]));
        if (tick_q[0].clear_integral) clears_sent++;
        void'(tick_q.pop_front());
        ticks_sent++;
      end
      if (taken || !item_valid) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          item_valid <= 1'b1;
          count_left <= tick_q[0].count_left;
          count_right <= tick_q[0].count_right;
          pitch_angle <= tick_q[0].pitch_angle;
          pitch_rate <= tick_q[0].pitch_rate;
          yaw_rate <= tick_q[0].yaw_rate;
          speed_target <= tick_q[0].speed_target;
          turn_command <= tick_q[0].turn_command;
          clear_integral <= tick_q[0].clear_integral;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) gap_left = 0;
            else if ($urandom_range(0, 1) == 0) gap_left = $urandom_range(1, 6);
            else gap_left = $urandom_range(1, 40);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // drive word monitor and result stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected drive word left %0d right %0d saturated %0b",
                   $time, drive_left, drive_right, saturated);
        end else begin
          want = drive_q.pop_front();
          if (drive_left !== want.left) begin
            mismatches++;
            $display("%0t: word %0d drive_left expected %0d got %0d",
                     $time, drives_checked, want.left, drive_left);
          end
          if (drive_right !== want.right) begin
            mismatches++;
            $display("%0t: word %0d drive_right expected %0d got %0d",
                     $time, drives_checked, want.right, drive_right);
          end
          if (saturated !== want.sat) begin
            mismatches++;
            $display("%0t: word %0d saturated expected %0b got %0b",
                     $time, drives_checked, want.sat, saturated);
          end
          if (want.sat) sat_seen++;
          drives_checked++;
        end
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 4));
          seg_left = $urandom_range(16, 400);
          if (stall_mode == HOLD) hold_left = $urandom_range(60, LONG_HOLD);
        end else begin
          seg_left--;
        end
        case (stall_mode)
          FLOW:    stall_next = 1'b0;
          LIGHT:   stall_next = ($urandom_range(0, 3) == 0);
          HEAVY:   stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ((seg_left % 7) < 3);
        endcase
      end
      result_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed ticks at reset settings
    add_tick(0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_tick(32767, 32767, 0, 0, 0, -32768, 0, 1'b0);
    add_tick(32767, 32767, 0, 0, 0, -32768, 0, 1'b0);
    add_tick(32767, 32767, 200, 0, 0, -32768, 0, 1'b0);
    add_tick(-32768, -32768, 0, 0, 0, 32767, 0, 1'b0);
    add_tick(-32768, -32768, 0, 0, 0, 32767, 0, 1'b0);
    add_tick(-32768, -32768, 0, 0, 0, 32767, 0, 1'b1);
    add_tick(0, 0, 46080, 0, 0, 0, 0, 1'b0);
    add_tick(0, 0, -46080, 0, 0, 0, 0, 1'b0);
    add_tick(0, 0, -65536, 32767, 0, 0, 0, 1'b0);
    add_tick(0, 0, 65535, -32768, 0, 0, 0, 1'b0);
    add_tick(0, 0, 0, 0, 32767, 0, 32767, 1'b0);
    add_tick(0, 0, 0, 0, -32768, 0, -32768, 1'b0);
    add_tick(3, 2, 100, -40, 200, 4, 10, 1'b0);
    add_tick(-5, 1, -300, 60, 5000, 0, -20, 1'b0);
    add_tick(-1, 1, 0, 0, 0, 0, 0, 1'b0);
    add_tick(-1, 0, 0, 0, 0, 0, 0, 1'b0);
    add_tick(0, 0, 0, 0, 0, 0, 0, 1'b1);

    for (int phase = 0; phase < N_SETTINGS; phase++) begin
      if (phase != 0) begin
        case (phase)
          1: begin
            queue_write(REG_MID_ANGLE, 32'd46080);
            queue_write(REG_DRIVE_LIMIT, 32'd32767);
          end
          2: begin
            queue_write(REG_MID_ANGLE, -32'sd46080);
            queue_write(REG_DRIVE_LIMIT, 32'd0);
          end
          3: begin
            queue_write(REG_UNUSED_LO, $urandom);
            queue_write(REG_MID_ANGLE, 32'd0);
            queue_write(REG_DRIVE_LIMIT, 32'd1);
            queue_write(REG_UNUSED_HI, $urandom);
          end
          4: begin
            queue_write(REG_MID_ANGLE, 32'hFFFF_0000);
            queue_write(REG_DRIVE_LIMIT, 32'hFFFF_FFFF);
          end
          N_SETTINGS - 1: begin
            queue_write(REG_MID_ANGLE, 32'(MID_ANGLE_RST));
            queue_write(REG_TILT_GAIN_P, TILT_GAIN_P_RST);
            queue_write(REG_TILT_GAIN_D, TILT_GAIN_D_RST);
            queue_write(REG_SPEED_GAIN_P, SPEED_GAIN_P_RST);
            queue_write(REG_SPEED_GAIN_I, SPEED_GAIN_I_RST);
            queue_write(REG_YAW_GAIN_D, YAW_GAIN_D_RST);
            queue_write(REG_YAW_GAIN_CMD, YAW_GAIN_CMD_RST);
            queue_write(REG_DRIVE_LIMIT, 32'(DRIVE_LIMIT_RST));
          end
          default: begin
            queue_write(REG_MID_ANGLE, 32'($urandom_range(0, 92160)) - 32'd46080);
            if ($urandom_range(0, 3) == 0)
              queue_write(REG_DRIVE_LIMIT, $urandom_range(0, 32767));
            else
              queue_write(REG_DRIVE_LIMIT, $urandom_range(100, 9000));
          end
        endcase
        if (phase != N_SETTINGS - 1) begin
          for (int r = REG_TILT_GAIN_P; r <= REG_YAW_GAIN_CMD; r++) begin
            if (phase == 1) queue_write(reg_index_t'(r), 32'h7FFF_FFFF);
            else if (phase == 2) queue_write(reg_index_t'(r), 32'h8000_0000);
            else queue_write(reg_index_t'(r), rand_gain());
          end
        end
        apply_settings();
      end
      repeat (RANDOM_PER_SETTING) tick_q.push_back(rand_tick());
      // long result hold-off while ticks keep coming
      if (phase == 1 || phase == 5) hold_toggle <= ~hold_toggle;
      settings_run++;
      while (tick_q.size() != 0 || drive_q.size() != 0 || item_valid) @(posedge clk);
      repeat (2) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d ticks and %0d drive words under %0d register settings (%0d writes)",
             ticks_sent, drives_checked, settings_run, reg_writes);
    $display("%0d words saturated, %0d ticks cleared the speed integral",
             sat_seen, clears_sent);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d drive words never arrived", mismatches, drive_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bcc_pkg.sv
rtl/balance_cascade_controller.sv
test/tb.sv
